// File: src/packet_channel_ref_patcher_defines.svh
// Assertion helpers used by the engine RTL.
`ifndef PACKET_CHANNEL_REF_PATCHER_DEFINES_SVH
`define PACKET_CHANNEL_REF_PATCHER_DEFINES_SVH

// Consequent checked in the same cycle.
`define PCRP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcrp assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PCRP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcrp assertion failed");

`endif

// File: src/pcrp_pkg.sv
`default_nettype none
package pcrp_pkg;

   localparam int MAX_PAYLOAD_BITS_DEF = 4096;
   localparam int MAX_PATCHES_DEF      = 16;
   localparam int REF_BITS_DEF         = 11;

   localparam logic [10:0] CHANNEL_LIMIT_RESET = 11'd1024;

   localparam logic [1:0] OP_ADD_PATCH = 2'd0;
   localparam logic [1:0] OP_DATA_BYTE = 2'd1;
   localparam logic [1:0] OP_FINISH    = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   localparam logic CSR_REG_CHANNEL_LIMIT = 1'b0;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [12:0] bit_offset;
      logic [9:0]  expected_channel;
      logic [9:0]  replacement_channel;
      logic [7:0]  data_byte;
      logic [15:0] payload_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        ok;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [12:0] bit_offset;
      logic [9:0]  expected_channel;
      logic [9:0]  replacement_channel;
   } patch_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } emit_type;

endpackage
`default_nettype wire

// File: src/pcrp_engine.sv
`default_nettype none
`include "packet_channel_ref_patcher_defines.svh"
module pcrp_engine #(
   parameter int MAX_PAYLOAD_BITS = pcrp_pkg::MAX_PAYLOAD_BITS_DEF,
   parameter int MAX_PATCHES      = pcrp_pkg::MAX_PATCHES_DEF,
   parameter int REF_BITS         = pcrp_pkg::REF_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcrp_pkg::req_type req,
   input  wire logic              req_accept,
   input  wire logic [10:0]       channel_limit,
   output logic                   busy,
   output pcrp_pkg::emit_type     emit,
   input  wire logic              emit_take
);

   localparam int STORE_BYTES = (MAX_PAYLOAD_BITS + 7) / 8;
   localparam int SA_W  = $clog2(STORE_BYTES);
   localparam int LB_W  = $clog2(STORE_BYTES + 1);
   localparam int PT_W  = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
   localparam int PC_W  = $clog2(MAX_PATCHES + 1);
   localparam int POS_W = (SA_W + 3 > 14) ? SA_W + 3 : 14;
   localparam int BI_W  = POS_W - 3;
   localparam int NB    = (REF_BITS + 14) / 8;
   localparam int GW    = 8 * NB;
   localparam int GC_W  = $clog2(NB);
   localparam int CHW   = (REF_BITS - 1 > 10) ? REF_BITS - 1 : 10;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHK, ST_RI, ST_RI_D, ST_RJ, ST_RJ_D, ST_V_RE, ST_V_RED,
      ST_G_A, ST_G_D, ST_V_CHK, ST_W_MOD, ST_W_WR, ST_E_A, ST_E_D, ST_E_OUT,
      ST_FAIL
   } state_type;

   state_type          state_ff;
   logic [PC_W-1:0]    cnt_ff, i_ff, j_ff;
   logic [LB_W-1:0]    loaded_ff, need_ff, ek_ff;
   logic               ovf_ff, phase_ff, last_ff;
   logic [15:0]        bits_ff;
   pcrp_pkg::patch_type cur_ff;
   logic [BI_W-1:0]    ba_ff, be_ff, fb_ff;
   logic [GC_W-1:0]    gcnt_ff;
   logic [GW-1:0]      gather_ff;
   logic [63:0]        word_ff;
   logic [3:0]         bc_ff;

   logic [7:0]          ps_mem [STORE_BYTES];
   logic [7:0]          ps_rd_ff;
   pcrp_pkg::patch_type pt_mem [MAX_PATCHES];
   pcrp_pkg::patch_type pt_rd_ff;

   logic [SA_W-1:0] ps_raddr;
   logic [PT_W-1:0] pt_raddr;
   logic            ps_we;
   logic [SA_W-1:0] ps_waddr;
   logic [7:0]      ps_wdata;
   logic            pt_we;

   logic [16:0]     need_w;
   logic            bad_job, range_bad, chan_bad, overlap;
   logic [POS_W-1:0] pos_cur, pos_ent, pos_first, pos_last;
   logic [2:0]      sh;
   logic [3:0]      sh1;
   logic [GW-1:0]   shifted, vmask, vbits, gather_acc;
   logic [CHW-1:0]  rep_ext;
   logic            ref_good;
   logic            last_i, last_j, last_b, last_e;
   logic [7:0]      wbyte;

   always_comb begin
      ps_raddr = '0;
      pt_raddr = '0;
      unique case (state_ff)
         ST_G_A:          ps_raddr = ba_ff[SA_W-1:0];
         ST_E_A:          ps_raddr = ek_ff[SA_W-1:0];
         ST_RI, ST_V_RE:  pt_raddr = i_ff[PT_W-1:0];
         ST_RJ:           pt_raddr = j_ff[PT_W-1:0];
         default: ;
      endcase
   end

   always_comb begin
      need_w    = ({1'b0, bits_ff} + 17'd7) >> 3;
      bad_job   = ovf_ff || (bits_ff == 16'd0) ||
                  (17'(bits_ff) > 17'(MAX_PAYLOAD_BITS)) || (need_w > 17'(loaded_ff));
      range_bad = (17'(pt_rd_ff.bit_offset) > 17'(bits_ff)) ||
                  ((17'(bits_ff) - 17'(pt_rd_ff.bit_offset)) < 17'(REF_BITS));
      chan_bad  = (pt_rd_ff.expected_channel == 10'd0) ||
                  (11'(pt_rd_ff.expected_channel) >= channel_limit) ||
                  (pt_rd_ff.replacement_channel == 10'd0) ||
                  (11'(pt_rd_ff.replacement_channel) >= channel_limit);
      pos_cur   = POS_W'(cur_ff.bit_offset);
      pos_ent   = POS_W'(pt_rd_ff.bit_offset);
      overlap   = (pos_cur < pos_ent + POS_W'(REF_BITS)) &&
                  (pos_ent < pos_cur + POS_W'(REF_BITS));
      pos_first = pos_ent;
      pos_last  = pos_ent + POS_W'(REF_BITS - 1);
      sh        = cur_ff.bit_offset[2:0];
      sh1       = {1'b0, sh} + 4'd1;
      shifted   = gather_ff >> sh;
      ref_good  = shifted[0] &&
                  (CHW'(shifted[REF_BITS-1:1]) == CHW'(cur_ff.expected_channel));
      rep_ext   = CHW'(cur_ff.replacement_channel);
      vmask     = ((GW'(1) << (REF_BITS - 1)) - GW'(1)) << sh1;
      vbits     = GW'(rep_ext[REF_BITS-2:0]) << sh1;
      gather_acc = gather_ff | (GW'(ps_rd_ff) << {gcnt_ff, 3'b000});
      wbyte     = 8'(gather_ff >> {gcnt_ff, 3'b000});
      last_i    = (i_ff + PC_W'(1)) == cnt_ff;
      last_j    = (j_ff + PC_W'(1)) == i_ff;
      last_b    = ba_ff == be_ff;
      last_e    = (ek_ff + LB_W'(1)) == need_ff;
   end

   always_comb begin
      pt_we    = req_accept && (req.opcode == pcrp_pkg::OP_ADD_PATCH) &&
                 (cnt_ff < PC_W'(MAX_PATCHES));
      ps_we    = 1'b0;
      ps_waddr = loaded_ff[SA_W-1:0];
      ps_wdata = req.data_byte;
      if (state_ff == ST_W_WR) begin
         ps_we    = 1'b1;
         ps_waddr = ba_ff[SA_W-1:0];
         ps_wdata = wbyte;
      end else if (req_accept && (req.opcode == pcrp_pkg::OP_DATA_BYTE) &&
                   (loaded_ff < LB_W'(STORE_BYTES))) begin
         ps_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ps_we) begin
         ps_mem[ps_waddr] <= ps_wdata;
      end
      ps_rd_ff <= ps_mem[ps_raddr];
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[cnt_ff[PT_W-1:0]] <= '{req.bit_offset, req.expected_channel,
                                       req.replacement_channel};
      end
      pt_rd_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         loaded_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  case (req.opcode)
                     pcrp_pkg::OP_ADD_PATCH: begin
                        if (cnt_ff < PC_W'(MAX_PATCHES)) begin
                           cnt_ff <= cnt_ff + PC_W'(1);
                        end else begin
                           ovf_ff <= 1'b1;
                        end
                     end
                     pcrp_pkg::OP_DATA_BYTE: begin
                        if (loaded_ff < LB_W'(STORE_BYTES)) begin
                           loaded_ff <= loaded_ff + LB_W'(1);
                        end
                     end
                     pcrp_pkg::OP_FINISH: begin
                        bits_ff  <= req.payload_bits;
                        state_ff <= ST_CHK;
                     end
                     default: ;
                  endcase
               end
            end
            ST_CHK: begin
               need_ff  <= need_w[LB_W-1:0];
               i_ff     <= '0;
               phase_ff <= 1'b0;
               ek_ff    <= '0;
               word_ff  <= '0;
               bc_ff    <= '0;
               if (bad_job) begin
                  state_ff <= ST_FAIL;
               end else if (cnt_ff == '0) begin
                  state_ff <= ST_E_A;
               end else begin
                  state_ff <= ST_RI;
               end
            end
            ST_RI: state_ff <= ST_RI_D;
            ST_RI_D: begin
               cur_ff <= pt_rd_ff;
               j_ff   <= '0;
               if (range_bad || chan_bad) begin
                  state_ff <= ST_FAIL;
               end else if (i_ff != '0) begin
                  state_ff <= ST_RJ;
               end else if (last_i) begin
                  i_ff     <= '0;
                  state_ff <= ST_V_RE;
               end else begin
                  i_ff     <= i_ff + PC_W'(1);
                  state_ff <= ST_RI;
               end
            end
            ST_RJ: state_ff <= ST_RJ_D;
            ST_RJ_D: begin
               if (overlap) begin
                  state_ff <= ST_FAIL;
               end else if (!last_j) begin
                  j_ff     <= j_ff + PC_W'(1);
                  state_ff <= ST_RJ;
               end else if (last_i) begin
                  i_ff     <= '0;
                  state_ff <= ST_V_RE;
               end else begin
                  i_ff     <= i_ff + PC_W'(1);
                  state_ff <= ST_RI;
               end
            end
            ST_V_RE: state_ff <= ST_V_RED;
            ST_V_RED: begin
               cur_ff    <= pt_rd_ff;
               ba_ff     <= pos_first[POS_W-1:3];
               fb_ff     <= pos_first[POS_W-1:3];
               be_ff     <= pos_last[POS_W-1:3];
               gather_ff <= '0;
               gcnt_ff   <= '0;
               state_ff  <= ST_G_A;
            end
            ST_G_A: state_ff <= ST_G_D;
            ST_G_D: begin
               gather_ff <= gather_acc;
               if (last_b) begin
                  state_ff <= phase_ff ? ST_W_MOD : ST_V_CHK;
               end else begin
                  ba_ff    <= ba_ff + BI_W'(1);
                  gcnt_ff  <= gcnt_ff + GC_W'(1);
                  state_ff <= ST_G_A;
               end
            end
            ST_V_CHK: begin
               if (!ref_good) begin
                  state_ff <= ST_FAIL;
               end else if (last_i) begin
                  i_ff     <= '0;
                  phase_ff <= 1'b1;
                  state_ff <= ST_V_RE;
               end else begin
                  i_ff     <= i_ff + PC_W'(1);
                  state_ff <= ST_V_RE;
               end
            end
            ST_W_MOD: begin
               gather_ff <= (gather_ff & ~vmask) | vbits;
               ba_ff     <= fb_ff;
               gcnt_ff   <= '0;
               state_ff  <= ST_W_WR;
            end
            ST_W_WR: begin
               if (!last_b) begin
                  ba_ff   <= ba_ff + BI_W'(1);
                  gcnt_ff <= gcnt_ff + GC_W'(1);
               end else if (last_i) begin
                  state_ff <= ST_E_A;
               end else begin
                  i_ff     <= i_ff + PC_W'(1);
                  state_ff <= ST_V_RE;
               end
            end
            ST_E_A: state_ff <= ST_E_D;
            ST_E_D: begin
               word_ff <= word_ff | (64'(ps_rd_ff) << {bc_ff[2:0], 3'b000});
               bc_ff   <= bc_ff + 4'd1;
               ek_ff   <= ek_ff + LB_W'(1);
               last_ff <= last_e;
               state_ff <= ((bc_ff == 4'd7) || last_e) ? ST_E_OUT : ST_E_A;
            end
            ST_E_OUT: begin
               if (emit_take) begin
                  word_ff <= '0;
                  bc_ff   <= '0;
                  if (last_ff) begin
                     cnt_ff    <= '0;
                     loaded_ff <= '0;
                     ovf_ff    <= 1'b0;
                     state_ff  <= ST_IDLE;
                  end else begin
                     state_ff <= ST_E_A;
                  end
               end
            end
            ST_FAIL: begin
               if (emit_take) begin
                  cnt_ff    <= '0;
                  loaded_ff <= '0;
                  ovf_ff    <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      busy       = state_ff != ST_IDLE;
      emit.valid = (state_ff == ST_E_OUT) || (state_ff == ST_FAIL);
      emit.item  = '{64'd0, 4'd0, 1'b0, 1'b1};
      if (state_ff == ST_E_OUT) begin
         emit.item = '{word_ff, bc_ff, 1'b1, last_ff};
      end
   end

   `PCRP_ASSERT_NEXT(a_last_to_idle, emit_take && emit.item.last, state_ff == ST_IDLE)
   `PCRP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= PC_W'(MAX_PATCHES))
   `PCRP_ASSERT_NOW(a_load_bound, 1'b1, loaded_ff <= LB_W'(STORE_BYTES))
   `PCRP_ASSERT_NOW(a_ok_has_bytes, emit.valid && emit.item.ok, emit.item.byte_count != 4'd0)

endmodule
`default_nettype wire

// File: src/packet_channel_ref_patcher.sv
// channel  | direction | handshake                  | payload
// req_     | in        | req_valid / req_stall      | pcrp_pkg::req_type
// rsp_     | out       | rsp_valid / rsp_stall      | pcrp_pkg::rsp_type
// apb      | in/out    | psel, penable, pready      | channel_limit at byte 0
//
// Add patch and data byte do not raise req_stall; finish holds req_stall until done.
// Finish: check the job, scan every entry for range and channel and every entry pair for
// overlap, verify the covered bytes of each patch, then modify and write them back.
// Emit: pack payload bytes into words of up to eight bytes, waiting while rsp_stall holds.
// Synchronous reset clears control only; the payload store and patch table need no clear.
`default_nettype none
module packet_channel_ref_patcher #(
   parameter int MAX_PAYLOAD_BITS = pcrp_pkg::MAX_PAYLOAD_BITS_DEF,
   parameter int MAX_PATCHES      = pcrp_pkg::MAX_PATCHES_DEF,
   parameter int REF_BITS         = pcrp_pkg::REF_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pcrp_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pcrp_pkg::rsp_type      rsp_item,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [10:0]        limit_ff;
   logic               rsp_valid_ff;
   pcrp_pkg::rsp_type  rsp_item_ff;
   logic               busy;
   pcrp_pkg::emit_type emit;
   logic               emit_take;
   logic               req_accept;

   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == pcrp_pkg::CSR_REG_CHANNEL_LIMIT) ? {21'd0, limit_ff} : 32'd0;
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign emit_take  = emit.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= pcrp_pkg::CHANNEL_LIMIT_RESET;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[2] == pcrp_pkg::CSR_REG_CHANNEL_LIMIT)) begin
         limit_ff <= pwdata[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_take) begin
         rsp_item_ff <= emit.item;
      end
   end

   pcrp_engine #(
      .MAX_PAYLOAD_BITS(MAX_PAYLOAD_BITS),
      .MAX_PATCHES     (MAX_PATCHES),
      .REF_BITS        (REF_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req          (req_item),
      .req_accept   (req_accept),
      .channel_limit(limit_ff),
      .busy         (busy),
      .emit         (emit),
      .emit_take    (emit_take)
   );

endmodule
`default_nettype wire
